### rtl/onu_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturation helpers for the online normalization unit.
// Depends on nothing; the top level refers to it by scoped names.
package onu_pkg;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SQRT = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_ACC  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    // Operation codes carried on s_tuser.
    localparam logic FUNC_FWD = 1'b0;
    localparam logic FUNC_BWD = 1'b1;

    // Register indexes on the configuration port.
    localparam logic REG_ALPHA       = 1'b0;
    localparam logic REG_ALPHA_PRIME = 1'b1;

    // Reset values and fixed-point constants.
    localparam logic [15:0] ALPHA_RST    = 16'd65470;
    localparam logic [17:0] Q_ONE        = 18'd65536;
    localparam logic [31:0] VAR_RST      = 32'd65536;
    localparam logic [4:0]  SQRT_STEPS   = 5'd24;
    localparam logic [5:0]  DIV_STEPS    = 6'd48;
    localparam logic [2:0]  FWD_LAST_OP  = 3'd6;
    localparam logic [2:0]  BWD_LAST_OP  = 3'd5;

    localparam logic signed [67:0] S32_MAX_W = 68'sd2147483647;
    localparam logic signed [67:0] S32_MIN_W = -(68'sd2147483648);

    // Clamp a wide signed value to 32 bits; the top bit reports a clamp.
    function automatic logic [32:0] sat32(input logic signed [67:0] v);
        logic [32:0] r;
        if (v > S32_MAX_W) begin
            r = {1'b1, 32'h7fff_ffff};
        end else if (v < S32_MIN_W) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

### rtl/online_normalization_unit.sv
`timescale 1ns / 1ps
// Online normalization unit: one channel of Q16.16 normalization and its gradient.
// Sequence: accept, 24 square-root steps, multiply passes on the shared multiplier,
// 48 divide steps and a finish state. One item at a time: a new item is accepted
// only after the last result has left the finish state; the bit-serial divider
// and square root take up most of each item's processing.
// Reset (aresetn low, synchronous) restores alpha, alpha_prime and all statistics.
// Depends on onu_pkg.
module online_normalization_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Input beat.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // sample [31:0], grad_in [63:32], fwd_value [95:64]
    input  logic        s_tuser,   // func
    // Result beat.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result [31:0]
    output logic        m_tuser,   // saturated
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    onu_pkg::state_t state_reg;

    logic [15:0] alpha_reg;
    logic [15:0] alpha_prime_reg;
    logic signed [31:0] mean_reg;
    logic signed [31:0] var_reg;
    logic signed [31:0] ep_reg;
    logic signed [31:0] ew_reg;

    logic               func_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] gy_reg;
    logic signed [31:0] y_reg;
    logic signed [32:0] d_reg;
    logic signed [31:0] g_reg;
    logic signed [33:0] e2_reg;
    logic signed [49:0] tmp_reg;
    logic               flag_reg;

    logic [2:0]  op_reg;
    logic [5:0]  cnt_reg;

    logic [47:0] rad_reg;
    logic [48:0] root_reg;
    logic [47:0] bit_reg;

    logic [47:0] num_reg;
    logic [23:0] rem_reg;
    logic        sign_reg;

    logic signed [67:0] prod_reg;
    logic signed [67:0] acc_reg;

    logic        m_valid_reg;
    logic [31:0] m_data_reg;
    logic        m_user_reg;

    // Handshakes.
    logic s_fire;
    logic cfg_wr;
    assign s_tready = (state_reg == onu_pkg::ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;

    // Register read-back.
    always_comb begin
        prdata = 32'd0;
        unique case (paddr[2])
            onu_pkg::REG_ALPHA:       prdata = {16'd0, alpha_reg};
            onu_pkg::REG_ALPHA_PRIME: prdata = {16'd0, alpha_prime_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // Complements of the decay factors, exact in 18 bits.
    logic signed [17:0] oma;
    logic signed [17:0] omap;
    logic signed [17:0] alpha_b;
    assign oma     = signed'(onu_pkg::Q_ONE - {2'b00, alpha_reg});
    assign omap    = signed'(onu_pkg::Q_ONE - {2'b00, alpha_prime_reg});
    assign alpha_b = signed'({2'b00, alpha_reg});

    // Magnitude of the forward difference, and the halves of y.
    logic [31:0]        ad;
    logic signed [17:0] y_lo;
    logic signed [17:0] y_hi;
    logic signed [31:0] s2;
    assign ad   = d_reg[32] ? 32'(-d_reg) : d_reg[31:0];
    assign y_lo = signed'({2'b00, y_reg[15:0]});
    assign y_hi = signed'({{2{y_reg[31]}}, y_reg[31:16]});
    assign s2   = var_reg[31] ? 32'sd0 : var_reg;

    // Operand selection for the shared multiplier.
    logic signed [49:0] mul_a;
    logic signed [17:0] mul_b;
    logic               acc_clr;
    logic               acc_sh;
    logic               last_op;
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        acc_clr = 1'b1;
        acc_sh  = 1'b0;
        if (func_reg == onu_pkg::FUNC_FWD) begin
            last_op = (op_reg == onu_pkg::FWD_LAST_OP);
            case (op_reg)
                3'd0: begin mul_a = 50'(mean_reg); mul_b = alpha_b; end
                3'd1: begin mul_a = 50'(x_reg); mul_b = oma; acc_clr = 1'b0; end
                3'd2: begin mul_a = signed'({18'd0, ad}); mul_b = signed'({2'b00, ad[15:0]}); end
                3'd3: begin
                    mul_a = signed'({18'd0, ad});
                    mul_b = signed'({2'b00, ad[31:16]});
                    acc_clr = 1'b0;
                    acc_sh = 1'b1;
                end
                3'd4: begin mul_a = tmp_reg; mul_b = alpha_b; end
                3'd5: begin mul_a = tmp_reg; mul_b = oma; end
                3'd6: begin mul_a = 50'(s2); mul_b = alpha_b; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else begin
            last_op = (op_reg == onu_pkg::BWD_LAST_OP);
            case (op_reg)
                3'd0: begin mul_a = 50'(ew_reg); mul_b = omap; end
                3'd1: begin mul_a = tmp_reg; mul_b = y_lo; end
                3'd2: begin mul_a = tmp_reg; mul_b = y_hi; acc_clr = 1'b0; acc_sh = 1'b1; end
                3'd3: begin mul_a = 50'(ep_reg); mul_b = omap; end
                3'd4: begin mul_a = 50'(g_reg); mul_b = y_lo; end
                3'd5: begin mul_a = 50'(g_reg); mul_b = y_hi; acc_clr = 1'b0; acc_sh = 1'b1; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    // Accumulator update and its floor-scaled view.
    logic signed [67:0] acc_next;
    logic signed [67:0] acc_q16;
    assign acc_next = (acc_clr ? 68'sd0 : acc_reg) + (acc_sh ? (prod_reg <<< 16) : prod_reg);
    assign acc_q16  = acc_next >>> 16;

    // Post-processing after each multiply pass.
    logic [32:0]        sat_mean;
    logic [32:0]        sat_var;
    logic [32:0]        sat_g;
    logic [32:0]        sat_ew;
    logic signed [49:0] t_cap;
    assign sat_mean = onu_pkg::sat32(acc_q16);
    assign sat_var  = onu_pkg::sat32(acc_q16 + 68'(tmp_reg));
    assign sat_g    = onu_pkg::sat32(68'(gy_reg) - acc_q16);
    assign sat_ew   = onu_pkg::sat32(68'(ew_reg) + acc_q16);
    assign t_cap    = (acc_q16 > onu_pkg::S32_MAX_W) ? 50'sd2147483648 : acc_q16[49:0];

    // One step of the digit-by-digit square root.
    logic [48:0] sq_sum;
    logic        sq_take;
    assign sq_sum  = root_reg + {1'b0, bit_reg};
    assign sq_take = ({1'b0, rad_reg} >= sq_sum);

    // One step of the restoring divider.
    logic [24:0] dv_rem2;
    logic        dv_take;
    assign dv_rem2 = {rem_reg, num_reg[47]};
    assign dv_take = (dv_rem2 >= {1'b0, root_reg[23:0]});

    // Final result from the quotient.
    logic signed [67:0] q_signed;
    logic [32:0]        sat_fwd;
    logic [32:0]        sat_gx;
    logic [32:0]        sat_ep;
    assign q_signed = sign_reg ? -signed'({20'd0, num_reg}) : signed'({20'd0, num_reg});
    assign sat_fwd  = onu_pkg::sat32(q_signed);
    assign sat_gx   = onu_pkg::sat32(q_signed - 68'(e2_reg));
    assign sat_ep   = onu_pkg::sat32(68'(ep_reg) + 68'(signed'(sat_gx[31:0])));

    logic var_floor;
    assign var_floor = (var_reg <= 32'sd0);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg       <= onu_pkg::ALPHA_RST;
            alpha_prime_reg <= onu_pkg::ALPHA_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                onu_pkg::REG_ALPHA:       alpha_reg       <= pwdata[15:0];
                onu_pkg::REG_ALPHA_PRIME: alpha_prime_reg <= pwdata[15:0];
                default:                  alpha_reg       <= alpha_reg;
            endcase
        end
    end

    // Output register: holds a finished beat until the sink takes it.
    logic fin_go;
    assign fin_go = (state_reg == onu_pkg::ST_FIN) && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_go) begin
            if (func_reg == onu_pkg::FUNC_FWD) begin
                m_data_reg <= sat_fwd[31:0];
                m_user_reg <= flag_reg | sat_fwd[32];
            end else begin
                m_data_reg <= sat_gx[31:0];
                m_user_reg <= flag_reg | sat_gx[32] | sat_ep[32];
            end
        end
    end

    // Sequencer and statistics.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= onu_pkg::ST_IDLE;
            mean_reg  <= 32'sd0;
            var_reg   <= signed'(onu_pkg::VAR_RST);
            ep_reg    <= 32'sd0;
            ew_reg    <= 32'sd0;
            op_reg    <= 3'd0;
            cnt_reg   <= 6'd0;
            flag_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                onu_pkg::ST_IDLE: begin
                    if (s_fire) begin
                        func_reg <= s_tuser;
                        x_reg    <= signed'(s_tdata[31:0]);
                        gy_reg   <= signed'(s_tdata[63:32]);
                        y_reg    <= signed'(s_tdata[95:64]);
                        d_reg    <= 33'(signed'(s_tdata[31:0])) - 33'(mean_reg);
                        flag_reg <= var_floor;
                        rad_reg  <= var_floor ? 48'h1_0000 : {var_reg[31:0], 16'd0};
                        root_reg <= 49'd0;
                        bit_reg  <= 48'd1 << 46;
                        cnt_reg  <= 6'd0;
                        op_reg   <= 3'd0;
                        state_reg <= onu_pkg::ST_SQRT;
                    end
                end
                onu_pkg::ST_SQRT: begin
                    if (sq_take) begin
                        rad_reg  <= rad_reg - sq_sum[47:0];
                        root_reg <= (root_reg >> 1) + {1'b0, bit_reg};
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg[4:0] == onu_pkg::SQRT_STEPS - 5'd1) begin
                        state_reg <= onu_pkg::ST_MUL;
                    end
                end
                onu_pkg::ST_MUL: begin
                    prod_reg  <= 68'(mul_a * mul_b);
                    state_reg <= onu_pkg::ST_ACC;
                end
                onu_pkg::ST_ACC: begin
                    acc_reg <= acc_next;
                    if (func_reg == onu_pkg::FUNC_FWD) begin
                        case (op_reg)
                            3'd1: begin
                                mean_reg <= signed'(sat_mean[31:0]);
                                flag_reg <= flag_reg | sat_mean[32];
                            end
                            3'd3, 3'd4: tmp_reg <= acc_q16[49:0];
                            3'd5: tmp_reg <= t_cap;
                            3'd6: begin
                                var_reg  <= signed'(sat_var[31:0]);
                                flag_reg <= flag_reg | sat_var[32];
                            end
                            default: tmp_reg <= tmp_reg;
                        endcase
                    end else begin
                        case (op_reg)
                            3'd0: tmp_reg <= acc_q16[49:0];
                            3'd2: begin
                                g_reg    <= signed'(sat_g[31:0]);
                                flag_reg <= flag_reg | sat_g[32];
                            end
                            3'd3: e2_reg <= acc_q16[33:0];
                            3'd5: begin
                                ew_reg   <= signed'(sat_ew[31:0]);
                                flag_reg <= flag_reg | sat_ew[32];
                            end
                            default: tmp_reg <= tmp_reg;
                        endcase
                    end
                    if (last_op) begin
                        // Load the divider with the magnitude shifted into Q16.16.
                        if (func_reg == onu_pkg::FUNC_FWD) begin
                            num_reg  <= {ad, 16'd0};
                            sign_reg <= d_reg[32];
                        end else begin
                            num_reg  <= {(g_reg[31] ? 32'(-g_reg) : g_reg[31:0]), 16'd0};
                            sign_reg <= g_reg[31];
                        end
                        rem_reg   <= 24'd0;
                        cnt_reg   <= 6'd0;
                        state_reg <= onu_pkg::ST_DIV;
                    end else begin
                        op_reg    <= op_reg + 3'd1;
                        state_reg <= onu_pkg::ST_MUL;
                    end
                end
                onu_pkg::ST_DIV: begin
                    if (dv_take) begin
                        rem_reg <= 24'(dv_rem2 - {1'b0, root_reg[23:0]});
                    end else begin
                        rem_reg <= dv_rem2[23:0];
                    end
                    num_reg <= {num_reg[46:0], dv_take};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == onu_pkg::DIV_STEPS - 6'd1) begin
                        state_reg <= onu_pkg::ST_FIN;
                    end
                end
                onu_pkg::ST_FIN: begin
                    if (fin_go) begin
                        if (func_reg == onu_pkg::FUNC_BWD) begin
                            ep_reg <= signed'(sat_ep[31:0]);
                        end
                        state_reg <= onu_pkg::ST_IDLE;
                    end
                end
                default: state_reg <= onu_pkg::ST_IDLE;
            endcase
        end
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the online normalization unit: directed and random
// forward and backward beats, APB register writes, checked by a bit-exact predictor.
// Depends on onu_pkg and online_normalization_unit.
module tb_top;

    localparam longint LIM_MAX = 64'sd2147483647;
    localparam longint LIM_MIN = -64'sd2147483648;
    localparam int CYCLE_LIMIT = 1200000;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } norm_result_t;

    // Scoreboard: the statistics and error sums of the unit, plus the queue of
    // results they imply.
    class norm_scoreboard;
        logic [15:0] alpha;
        logic [15:0] alpha_prime;
        longint mean, variance, err_plain, err_weighted;
        norm_result_t pending[$];
        int errors;

        function void reset_state();
            alpha = onu_pkg::ALPHA_RST;
            alpha_prime = onu_pkg::ALPHA_RST;
            mean = 0;
            variance = 65536;
            err_plain = 0;
            err_weighted = 0;
            pending.delete();
            errors = 0;
        endfunction

        // Floor division by 2^16.
        function longint fl16(longint v);
            return v >>> 16;
        endfunction

        function longint clip(longint v, ref logic sat);
            if (v > LIM_MAX) begin
                sat = 1'b1;
                return LIM_MAX;
            end
            if (v < LIM_MIN) begin
                sat = 1'b1;
                return LIM_MIN;
            end
            return v;
        endfunction

        function longint root64(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return longint'(r);
        endfunction

        // Predict the result of one accepted input beat and update the state.
        function void note_input(logic func, logic [31:0] xs, logic [31:0] gys,
                                 logic [31:0] ys);
            logic sat;
            longint sd, v, res, x, d, s2, a, oma, nv, gy, y, omap, g, gx;
            longint unsigned ad, t;
            sat = 1'b0;
            v = variance;
            if (v <= 0) begin
                v = 1;
                sat = 1'b1;
            end
            sd = root64(longint'(v) << 16);
            if (func == onu_pkg::FUNC_FWD) begin
                x = longint'(signed'(xs));
                s2 = (variance < 0) ? 0 : variance;
                a = longint'(alpha);
                oma = 65536 - a;
                d = x - mean;
                ad = (d < 0) ? -d : d;
                res = clip((d * 65536) / sd, sat);
                mean = clip(fl16(a * mean + oma * x), sat);
                t = (ad * ad) >> 16;
                t = (t * a) >> 16;
                t = (t * oma) >> 16;
                if (t > 64'd2147483647) t = 64'd2147483648;
                nv = fl16(a * s2) + longint'(t);
                variance = clip(nv, sat);
            end else begin
                gy = longint'(signed'(gys));
                y = longint'(signed'(ys));
                omap = 65536 - longint'(alpha_prime);
                g = gy - fl16(fl16(omap * err_weighted) * y);
                g = clip(g, sat);
                gx = (g * 65536) / sd - fl16(omap * err_plain);
                res = clip(gx, sat);
                err_weighted = clip(err_weighted + fl16(g * y), sat);
                err_plain = clip(err_plain + res, sat);
            end
            pending.push_back('{value: res[31:0], sat: sat});
        endfunction

        // Compare one result beat with the oldest prediction.
        function void check_result(logic [31:0] value, logic sat);
            norm_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat %h sat %b", $time, value, sat);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.value !== value) begin
                $display("%0t: result expected %h actual %h", $time, e.value, value);
                errors++;
            end
            if (e.sat !== sat) begin
                $display("%0t: saturated expected %b actual %b", $time, e.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;   // sample [31:0], grad_in [63:32], fwd_value [95:64]
    logic        s_tuser = 1'b0; // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // result [31:0]
    logic        m_tuser;        // saturated
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    norm_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int cycles;

    online_normalization_unit i_dut (.*);

    // Clock.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Receiver: random stall, checking each accepted beat.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // APB write of one register, setup then access.
    task automatic write_reg(logic idx, logic [15:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'h0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == onu_pkg::REG_ALPHA) sb.alpha = value;
        else sb.alpha_prime = value;
    endtask

    // Send one input beat; random gaps come before it. The valid stays high
    // after acceptance until the next beat or a gap replaces it.
    task automatic send_item(logic func, logic [31:0] x, logic [31:0] gy, logic [31:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {y, gy, x};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(func, x, gy, y);
    endtask

    // Drop the valid, wait until all results are in, then let the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(8) * 32'h0001_0000 - 32'h0004_0000;
            3: return {{16{$urandom_range(1) == 1}}, 16'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    task automatic random_phase(int n, int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (n) begin
            send_item(logic'($urandom_range(1)), rand_value(), rand_value(), rand_value());
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, both operations, floored variance and clamps.
        send_item(onu_pkg::FUNC_FWD, 32'h0001_0000, '0, '0);
        send_item(onu_pkg::FUNC_FWD, 32'h7fff_ffff, '0, '0);
        send_item(onu_pkg::FUNC_FWD, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff);
        send_item(onu_pkg::FUNC_BWD, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_item(onu_pkg::FUNC_BWD, '0, 32'h8000_0000, 32'h8000_0000);
        send_item(onu_pkg::FUNC_BWD, '0, 32'h0001_0000, 32'hffff_0000);
        drain();
        // Alpha of zero forgets everything; a constant input drives variance to zero.
        write_reg(onu_pkg::REG_ALPHA, 16'h0000);
        write_reg(onu_pkg::REG_ALPHA_PRIME, 16'h0000);
        repeat (3) send_item(onu_pkg::FUNC_FWD, 32'h0003_0000, '0, '0);
        send_item(onu_pkg::FUNC_BWD, '0, 32'h0002_0000, 32'h0001_0000);
        send_item(onu_pkg::FUNC_BWD, '0, 32'h7fff_0000, 32'h7fff_0000);
        drain();
        write_reg(onu_pkg::REG_ALPHA, 16'hffff);
        write_reg(onu_pkg::REG_ALPHA_PRIME, 16'hffff);
        send_item(onu_pkg::FUNC_FWD, 32'h4000_0000, '0, '0);
        send_item(onu_pkg::FUNC_BWD, '0, 32'hc000_0000, 32'h0100_0000);
        drain();

        random_phase(200, 28, 70);
        drain();
        write_reg(onu_pkg::REG_ALPHA, 16'h8000);
        write_reg(onu_pkg::REG_ALPHA_PRIME, 16'h0100);
        random_phase(200, 70, 28);
        drain();
        write_reg(onu_pkg::REG_ALPHA, 16'($urandom()));
        write_reg(onu_pkg::REG_ALPHA_PRIME, 16'($urandom()));
        random_phase(400, 0, 0);
        drain();
        write_reg(onu_pkg::REG_ALPHA, onu_pkg::ALPHA_RST);
        write_reg(onu_pkg::REG_ALPHA_PRIME, 16'hffff);
        random_phase(430, $urandom_range(30), $urandom_range(30));
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/onu_pkg.sv
rtl/online_normalization_unit.sv
dv/tb_top.sv
